FILE: sv/srb_pkg.sv
// Shared types and constants for the sequence reorder buffer.
// Used by srb_ctrl, srb_datapath and sequence_reorder_buffer; no dependencies.
`default_nettype none

package srb_pkg;

  // Most results one transaction may produce, counting a reject
  localparam int MAX_RESULTS = 32;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    ST_APPLIED   = 2'd0,
    ST_STALE     = 2'd1,
    ST_BEYOND    = 2'd2,
    ST_DUPLICATE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;   // capture the input transaction
    logic check;  // classify, store, prime the first read
    logic emit;   // release the expected entry
  } srb_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic reject;      // input gives a status result
    logic drain_go;    // expected slot ready after the check
    logic drain_more;  // another release follows this one
  } srb_stat_t;

endpackage

`default_nettype wire

FILE: sv/srb_ctrl.sv
// Controller state machine for the sequence reorder buffer.
// Depends on srb_pkg; drives srb_datapath through srb_cmd_t.
`default_nettype none

module srb_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire srb_pkg::srb_stat_t stat,
  output srb_pkg::srb_cmd_t       cmd,
  output logic                    busy,
  output logic                    out_strobe
);

  srb_pkg::state_t state;
  srb_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srb_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    out_strobe = 1'b0;
    unique case (state)
      srb_pkg::S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
        if (start) begin
          state_next = srb_pkg::S_CHECK;
        end
      end
      srb_pkg::S_CHECK: begin
        cmd.check  = 1'b1;
        out_strobe = stat.reject;
        state_next = stat.drain_go ? srb_pkg::S_EMIT : srb_pkg::S_IDLE;
      end
      srb_pkg::S_EMIT: begin
        cmd.emit   = 1'b1;
        out_strobe = 1'b1;
        state_next = stat.drain_more ? srb_pkg::S_EMIT : srb_pkg::S_IDLE;
      end
      default: begin
        state_next = srb_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/srb_datapath.sv
// Datapath of the sequence reorder buffer: window check, ring store, valid bits,
// expected sequence and result fields. Depends on srb_pkg.
`default_nettype none

module srb_datapath #(
  parameter int WINDOW = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire srb_pkg::srb_cmd_t  cmd,
  output srb_pkg::srb_stat_t      stat,
  input  wire logic [31:0]        seq_number,
  input  wire logic [7:0]         origin_node,
  input  wire logic [31:0]        request_uid,
  input  wire logic [31:0]        payload_ref,
  output logic [31:0]             out_seq,
  output logic [7:0]              out_node,
  output logic [31:0]             out_uid,
  output logic [31:0]             out_payload,
  output logic [1:0]              status,
  output logic                    last
);

  localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  // Captured transaction
  logic [31:0] in_seq;
  logic [7:0]  in_node;
  logic [31:0] in_uid;
  logic [31:0] in_payload;

  logic [31:0]              expected;
  logic [IW-1:0]            exp_idx;
  logic [WINDOW-1:0]        slot_valid;
  logic [srb_pkg::CNT_W-1:0] cnt;

  logic [39:0] slot_origin  [WINDOW];
  logic [31:0] slot_payload [WINDOW];
  logic [39:0] rd_origin;
  logic [31:0] rd_payload;

  logic [32:0]     diff;
  logic            wrapped;
  logic [31:0]     gap;
  logic            in_window;
  logic [IW:0]     idx_sum;
  logic [IW-1:0]   st_idx;
  logic            dup;
  logic            store;
  logic            store_hit;
  srb_pkg::status_t class_code;
  logic [IW-1:0]   nxt_idx;
  logic [srb_pkg::CNT_W-1:0] cnt_inc;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_seq     <= seq_number;
      in_node    <= origin_node;
      in_uid     <= request_uid;
      in_payload <= payload_ref;
    end
  end

  // Window test; borrow marks a sequence number that wrapped past zero
  always_comb begin
    diff      = {1'b0, in_seq} - {1'b0, expected};
    wrapped   = diff[32];
    gap       = diff[31:0];
    in_window = gap < 32'(WINDOW);
    idx_sum   = {1'b0, exp_idx} + {1'b0, gap[IW-1:0]};
    if (wrapped) begin
      st_idx = in_seq[IW-1:0];
    end else if (idx_sum >= (IW+1)'(WINDOW)) begin
      st_idx = IW'(idx_sum - (IW+1)'(WINDOW));
    end else begin
      st_idx = idx_sum[IW-1:0];
    end
    dup       = in_window && slot_valid[st_idx];
    store     = in_window && !slot_valid[st_idx];
    store_hit = store && (st_idx == exp_idx);
    if (!in_window && gap[31]) begin
      class_code = srb_pkg::ST_STALE;
    end else if (!in_window) begin
      class_code = srb_pkg::ST_BEYOND;
    end else if (dup) begin
      class_code = srb_pkg::ST_DUPLICATE;
    end else begin
      class_code = srb_pkg::ST_APPLIED;
    end
  end

  // Ring index of expected + 1; restart at zero when the sequence wraps
  always_comb begin
    if (expected == 32'hFFFF_FFFF) begin
      nxt_idx = '0;
    end else if (exp_idx == IW'(WINDOW - 1)) begin
      nxt_idx = '0;
    end else begin
      nxt_idx = exp_idx + 1'b1;
    end
    cnt_inc = cnt + 1'b1;
  end

  // A wrap back onto the slot being released ends the drain
  always_comb begin
    stat.reject     = !store;
    stat.drain_go   = (slot_valid[exp_idx] || store_hit) &&
                      ({{(srb_pkg::CNT_W-1){1'b0}}, !store} <
                       srb_pkg::CNT_W'(srb_pkg::MAX_RESULTS));
    stat.drain_more = slot_valid[nxt_idx] && (nxt_idx != exp_idx) &&
                      (cnt_inc < srb_pkg::CNT_W'(srb_pkg::MAX_RESULTS));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected   <= '0;
      exp_idx    <= '0;
      slot_valid <= '0;
      cnt        <= '0;
    end else begin
      if (cmd.load) begin
        cnt <= '0;
      end else if (cmd.check) begin
        cnt <= {{(srb_pkg::CNT_W-1){1'b0}}, !store};
        if (store) begin
          slot_valid[st_idx] <= 1'b1;
        end
      end else if (cmd.emit) begin
        cnt                 <= cnt_inc;
        slot_valid[exp_idx] <= 1'b0;
        expected            <= expected + 32'd1;
        exp_idx             <= nxt_idx;
      end
    end
  end

  // Ring store; forward the incoming entry when it lands on the expected slot
  always_ff @(posedge clk) begin
    if (cmd.check && store) begin
      slot_origin[st_idx]  <= {in_node, in_uid};
      slot_payload[st_idx] <= in_payload;
    end
    if (cmd.check) begin
      if (store_hit) begin
        rd_origin  <= {in_node, in_uid};
        rd_payload <= in_payload;
      end else begin
        rd_origin  <= slot_origin[exp_idx];
        rd_payload <= slot_payload[exp_idx];
      end
    end else if (cmd.emit) begin
      rd_origin  <= slot_origin[nxt_idx];
      rd_payload <= slot_payload[nxt_idx];
    end
  end

  always_comb begin
    if (cmd.emit) begin
      out_seq     = expected;
      out_node    = rd_origin[39:32];
      out_uid     = rd_origin[31:0];
      out_payload = rd_payload;
      status      = srb_pkg::ST_APPLIED;
      last        = !stat.drain_more;
    end else begin
      out_seq     = in_seq;
      out_node    = in_node;
      out_uid     = in_uid;
      out_payload = in_payload;
      status      = class_code;
      last        = !stat.drain_go;
    end
  end

endmodule

`default_nettype wire

FILE: sv/sequence_reorder_buffer.sv
// Sequence reorder buffer: a rejected transaction gives its status result in the cycle
// after acceptance; released entries follow one per cycle from the ring store read port.
// Busy stays high from acceptance until the last entry is released, and a new transaction
// is taken only while idle. Results are strobed for one cycle; the receiver cannot stall.
// Reset clears the expected sequence and all slot valid bits; store contents stay as is.
// Depends on srb_pkg, srb_ctrl and srb_datapath.
`default_nettype none

module sequence_reorder_buffer #(
  parameter int WINDOW = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] seq_number,
  input  wire logic [7:0]  origin_node,
  input  wire logic [31:0] request_uid,
  input  wire logic [31:0] payload_ref,
  output logic             out_strobe,
  output logic [31:0]      out_seq,
  output logic [7:0]       out_node,
  output logic [31:0]      out_uid,
  output logic [31:0]      out_payload,
  output logic [1:0]       status,
  output logic             last
);

  srb_pkg::srb_cmd_t  cmd;
  srb_pkg::srb_stat_t stat;

  srb_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy),
    .out_strobe (out_strobe)
  );

  srb_datapath #(
    .WINDOW (WINDOW)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .seq_number  (seq_number),
    .origin_node (origin_node),
    .request_uid (request_uid),
    .payload_ref (payload_ref),
    .out_seq     (out_seq),
    .out_node    (out_node),
    .out_uid     (out_uid),
    .out_payload (out_payload),
    .status      (status),
    .last        (last)
  );

endmodule

`default_nettype wire
